// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the skeleton pose quality qualifier.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned NUM_JOINTS_DEF = 20;
  localparam int unsigned POS_WIDTH_DEF  = 16;

  localparam int unsigned JIDX_W  = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned THR_W   = 5;
  localparam int unsigned CUT_W   = 16;
  localparam int unsigned MASK_W  = 20;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DW  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOSS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd3;

  localparam logic [THR_W-1:0]  LOSS_RST   = 5'd0;
  localparam logic [THR_W-1:0]  REGAIN_RST = 5'd20;
  localparam logic [CUT_W-1:0]  CUTOFF_RST = 16'd36045;
  localparam logic [MASK_W-1:0] MASK_RST   = 20'hCC000;

  // Key joint slots in the position store.
  localparam int unsigned NUM_SLOTS = 7;
  localparam logic [2:0] SLOT_J2   = 3'd0;
  localparam logic [2:0] SLOT_J4   = 3'd1;
  localparam logic [2:0] SLOT_J8   = 3'd2;
  localparam logic [2:0] SLOT_J12  = 3'd3;
  localparam logic [2:0] SLOT_J13  = 3'd4;
  localparam logic [2:0] SLOT_J15  = 3'd5;
  localparam logic [2:0] SLOT_J16  = 3'd6;
  localparam logic [2:0] SLOT_NONE = 3'd7;

  typedef struct packed {
    logic [THR_W-1:0]  loss;
    logic [THR_W-1:0]  regain;
    logic [CUT_W-1:0]  cutoff;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  // Per-frame information handed from the front to the back.
  typedef struct packed {
    logic             strict;
    logic             playing;
    logic             usable;
    logic             in_range;
    logic [CNT_W-1:0] count;
  } frame_info_t;

  function automatic logic [2:0] key_slot(input logic [JIDX_W-1:0] j);
    logic [2:0] s;
    unique case (j)
      5'd2:    s = SLOT_J2;
      5'd4:    s = SLOT_J4;
      5'd8:    s = SLOT_J8;
      5'd12:   s = SLOT_J12;
      5'd13:   s = SLOT_J13;
      5'd15:   s = SLOT_J15;
      5'd16:   s = SLOT_J16;
      default: s = SLOT_NONE;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/spq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_fifo
// Two-entry queue of finished frames between the front and the back.
// ----------------------------------------------------------------------------
module spq_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output logic [W-1:0] head_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, wr_d, rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = ~wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rd_d  = ~rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/spq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_front
// Takes joint words, counts confident joints, keeps key joint positions and
// queues a frame record on the last joint.
// ----------------------------------------------------------------------------
module spq_front #(
  parameter int unsigned NUM_JOINTS = spq_pkg::NUM_JOINTS_DEF,
  parameter int unsigned POS_WIDTH  = spq_pkg::POS_WIDTH_DEF,
  localparam int unsigned KW = spq_pkg::NUM_SLOTS * 3 * POS_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [spq_pkg::MASK_W-1:0]   mask_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [spq_pkg::JIDX_W-1:0]   joint_index_i,
  input  logic                         joint_tracked_i,
  input  logic [3*POS_WIDTH-1:0]       pos_i,
  input  logic                         last_i,
  input  logic [3:0]                   flags_i,
  input  logic                         full_i,
  output logic                         push_o,
  output spq_pkg::frame_info_t         info_o,
  output logic [KW-1:0]                keys_o
);

  logic [3*POS_WIDTH-1:0]    key_q [spq_pkg::NUM_SLOTS];
  logic [spq_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_new;
  logic                      acc, in_set, forced;
  logic [31:0]               mask_ext;
  logic [2:0]                slot;

  assign ready_o  = ~full_i;
  assign acc      = valid_i & ready_o;
  assign in_set   = ({1'b0, joint_index_i} < 6'(NUM_JOINTS));
  assign mask_ext = {{(32 - spq_pkg::MASK_W){1'b0}}, mask_i};
  assign forced   = mask_ext[joint_index_i];
  assign slot     = in_set ? spq_pkg::key_slot(joint_index_i) : spq_pkg::SLOT_NONE;

  always_comb begin
    cnt_new = cnt_q;
    if (in_set && (joint_tracked_i || forced) && (cnt_q != 5'd31)) begin
      cnt_new = cnt_q + 5'd1;
    end
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = last_i ? '0 : cnt_new;
    end
  end

  // The queued snapshot already includes this joint's position.
  always_comb begin
    for (int s = 0; s < spq_pkg::NUM_SLOTS; s++) begin
      keys_o[s*3*POS_WIDTH +: 3*POS_WIDTH] = (slot == 3'(s)) ? pos_i : key_q[s];
    end
  end

  assign push_o           = acc & last_i;
  assign info_o.strict    = flags_i[3];
  assign info_o.playing   = flags_i[2];
  assign info_o.usable    = flags_i[1];
  assign info_o.in_range  = flags_i[0];
  assign info_o.count     = cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && slot != spq_pkg::SLOT_NONE) begin
      key_q[slot] <= pos_i;
    end
  end

endmodule

// File: rtl/spq_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_mul
// Unsigned multiplier that takes eight bits of the second operand a cycle.
// ----------------------------------------------------------------------------
module spq_mul #(
  parameter int unsigned MW = 48,
  localparam int unsigned PW = 2 * MW,
  localparam int unsigned NSTEP = MW / 8,
  localparam int unsigned CNTW = $clog2(NSTEP + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] a_i,
  input  logic [MW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  logic [PW-1:0]   a_q, acc_q;
  logic [MW-1:0]   b_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [PW-1:0]   part;

  // The shifted operand never exceeds PW bits, so the low PW bits are exact.
  assign part   = a_q * PW'(b_q[7:0]);
  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CNTW'(NSTEP);
      end else if (busy_q) begin
        cnt_q  <= cnt_q - CNTW'(1);
        busy_q <= (cnt_q != CNTW'(1));
        done_q <= (cnt_q == CNTW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{MW{1'b0}}, a_i};
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
      a_q   <= a_q << 8;
      b_q   <= b_q >> 8;
    end
  end

endmodule

// File: rtl/spq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_back
// Evaluates one queued frame with a shared multiplier and updates the flags.
// ----------------------------------------------------------------------------
module spq_back #(
  parameter int unsigned POS_WIDTH = spq_pkg::POS_WIDTH_DEF,
  localparam int unsigned KW  = spq_pkg::NUM_SLOTS * 3 * POS_WIDTH,
  localparam int unsigned DW  = POS_WIDTH + 1,
  localparam int unsigned SQW = 2 * DW,
  localparam int unsigned LW  = SQW + 2,
  localparam int unsigned NMW = (SQW + 9 > 32) ? SQW + 9 : 32,
  localparam int unsigned MW  = ((NMW + 7) / 8) * 8,
  localparam int unsigned PW  = 2 * MW,
  localparam int unsigned LHW = SQW + 39,
  localparam int unsigned CW  = (PW > LHW) ? PW : LHW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spq_pkg::cfg_t                cfg_i,
  input  logic                         empty_i,
  input  spq_pkg::frame_info_t         info_i,
  input  logic [KW-1:0]                keys_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spq_pkg::OUT_DW-1:0]   out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [4:0] STEP_VZ   = 5'd2;
  localparam logic [4:0] STEP_Y1   = 5'd13;
  localparam logic [4:0] STEP_Y2   = 5'd16;
  localparam logic [4:0] STEP_C2   = 5'd18;
  localparam logic [4:0] STEP_RHS  = 5'd19;
  localparam logic [4:0] STEP_AB   = 5'd20;
  localparam logic [4:0] STEP_LAST = 5'd21;

  localparam int unsigned BW = SQW + 7;
  localparam int unsigned XW = SQW + 9;

  logic [1:0]  state_q, state_d;
  logic [4:0]  step_q, step_d;

  logic valid_q, conf_q, side_q, sit_q;
  logic valid_d, conf_d, side_d, sit_d;

  logic [LW-1:0]         lv_q, la_q, lb_q, l1_q, l2_q;
  logic [SQW-1:0]        vz2_q, y1sq_q, y2sq_q;
  logic                  y1neg_q, y2neg_q;
  logic signed [LW-1:0]  dot_q;
  logic [31:0]           c2_q;
  logic [PW-1:0]         rhs_q, pab_q;

  logic                  out_v_q;
  logic [spq_pkg::OUT_DW-1:0] out_q;

  logic [2:0]  to_s, from_s;
  logic [1:0]  comp;
  logic signed [DW-1:0] d_main, d_b;
  logic [DW-1:0] m_main, m_b;
  logic [MW-1:0] op_a, op_b;
  logic          mstart, mdone;
  logic [PW-1:0] prod;
  logic [LW-1:0] psmall;
  logic          out_free;

  function automatic logic signed [POS_WIDTH-1:0] key_at(
    input logic [KW-1:0] k, input logic [2:0] s, input logic [1:0] c);
    return k[(32'(s) * 3 + 32'(c)) * POS_WIDTH +: POS_WIDTH];
  endfunction

  // Operand routing for each step of the evaluation sequence.
  always_comb begin
    to_s   = spq_pkg::SLOT_J8;
    from_s = spq_pkg::SLOT_J4;
    comp   = 2'(step_q);
    if (step_q < 5'd3) begin
      comp = 2'(step_q);
    end else if (step_q < 5'd6) begin
      from_s = spq_pkg::SLOT_J2;
      comp   = 2'(step_q - 5'd3);
    end else if (step_q < 5'd9) begin
      to_s   = spq_pkg::SLOT_J4;
      from_s = spq_pkg::SLOT_J2;
      comp   = 2'(step_q - 5'd6);
    end else if (step_q < 5'd12) begin
      from_s = spq_pkg::SLOT_J2;
      comp   = 2'(step_q - 5'd9);
    end else if (step_q < 5'd15) begin
      to_s   = spq_pkg::SLOT_J13;
      from_s = spq_pkg::SLOT_J12;
      comp   = 2'(step_q - 5'd12);
    end else if (step_q < 5'd18) begin
      to_s   = spq_pkg::SLOT_J16;
      from_s = spq_pkg::SLOT_J15;
      comp   = 2'(step_q - 5'd15);
    end else begin
      comp = 2'd0;
    end
  end

  assign d_main = DW'(key_at(keys_i, to_s, comp)) - DW'(key_at(keys_i, from_s, comp));
  assign d_b    = DW'(key_at(keys_i, spq_pkg::SLOT_J4, comp))
                - DW'(key_at(keys_i, spq_pkg::SLOT_J2, comp));
  assign m_main = d_main[DW-1] ? DW'(-d_main) : DW'(d_main);
  assign m_b    = d_b[DW-1] ? DW'(-d_b) : DW'(d_b);

  always_comb begin
    op_a = MW'(m_main);
    op_b = MW'(m_main);
    if (step_q >= 5'd9 && step_q < 5'd12) begin
      op_b = MW'(m_b);
    end else if (step_q == STEP_C2) begin
      op_a = MW'(cfg_i.cutoff);
      op_b = MW'(cfg_i.cutoff);
    end else if (step_q == STEP_RHS) begin
      op_a = MW'(c2_q);
      op_b = side_q ? MW'(lv_q) * MW'(81) : MW'(lv_q);
    end else if (step_q == STEP_AB) begin
      op_a = MW'(la_q);
      op_b = MW'(lb_q);
    end else if (step_q == STEP_LAST) begin
      op_a = (dot_q > 0) ? MW'({dot_q, 2'b00}) : '0;
      op_b = op_a;
    end
  end

  assign mstart = (state_q == S_MUL);

  spq_mul #(.MW(MW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mstart),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mdone),
    .prod_o (prod)
  );

  assign psmall = prod[LW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      lv_q  <= '0;
      la_q  <= '0;
      lb_q  <= '0;
      l1_q  <= '0;
      l2_q  <= '0;
      dot_q <= '0;
    end else if (state_q == S_WAIT && mdone) begin
      if (step_q < 5'd3) begin
        lv_q <= lv_q + psmall;
        if (step_q == STEP_VZ) begin
          vz2_q <= prod[SQW-1:0];
        end
      end else if (step_q < 5'd6) begin
        la_q <= la_q + psmall;
      end else if (step_q < 5'd9) begin
        lb_q <= lb_q + psmall;
      end else if (step_q < 5'd12) begin
        dot_q <= (d_main[DW-1] ^ d_b[DW-1]) ? dot_q - $signed(psmall)
                                            : dot_q + $signed(psmall);
      end else if (step_q < 5'd15) begin
        l1_q <= l1_q + psmall;
        if (step_q == STEP_Y1) begin
          y1sq_q  <= prod[SQW-1:0];
          y1neg_q <= d_main[DW-1];
        end
      end else if (step_q < 5'd18) begin
        l2_q <= l2_q + psmall;
        if (step_q == STEP_Y2) begin
          y2sq_q  <= prod[SQW-1:0];
          y2neg_q <= d_main[DW-1];
        end
      end else if (step_q == STEP_C2) begin
        c2_q <= prod[31:0];
      end else if (step_q == STEP_RHS) begin
        rhs_q <= prod;
      end else if (step_q == STEP_AB) begin
        pab_q <= prod;
      end
    end
  end

  // Final decision; the angle product is taken straight from the multiplier.
  logic [BW-1:0] lhs_base;
  logic [CW-1:0]  lhs, rhs_ext;
  logic           side_tilt, side_angle;
  logic           above1, above2, below1, below2;
  logic           strict_chk;

  always_comb begin
    lhs_base   = side_q ? BW'(vz2_q) * BW'(100) : BW'(vz2_q);
    lhs        = CW'(lhs_base) << 32;
    rhs_ext    = CW'(rhs_q);
    side_tilt  = (lv_q == '0) ? (cfg_i.cutoff != '0) : (lhs < rhs_ext);
    side_angle = (dot_q > 0) && (pab_q < prod);
    above1 = !y1neg_q || (XW'(y1sq_q) * XW'(100) < XW'(l1_q) * XW'(49));
    above2 = !y2neg_q || (XW'(y2sq_q) * XW'(100) < XW'(l2_q) * XW'(49));
    below1 = y1neg_q && (XW'(y1sq_q) * XW'(100) > XW'(l1_q) * XW'(64));
    below2 = y2neg_q && (XW'(y2sq_q) * XW'(100) > XW'(l2_q) * XW'(64));
    strict_chk = info_i.strict || !info_i.playing;

    valid_d = valid_q;
    conf_d  = conf_q;
    side_d  = side_q;
    sit_d   = sit_q;
    if (info_i.in_range) begin
      if (!info_i.usable) begin
        valid_d = 1'b0;
        conf_d  = 1'b0;
        side_d  = 1'b0;
        sit_d   = 1'b0;
      end else begin
        if (info_i.count < cfg_i.loss) begin
          conf_d = 1'b0;
        end
        if (info_i.count > cfg_i.regain) begin
          conf_d = 1'b1;
        end
        side_d = side_tilt || side_angle;
        if (!sit_q) begin
          sit_d = above1 && above2;
        end else begin
          sit_d = !(below1 && below2);
        end
        valid_d = strict_chk ? (conf_d && !side_d && !sit_d) : 1'b1;
      end
    end
  end

  assign out_free = !out_v_q || out_ready_i;
  assign pop_o    = (state_q == S_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (!empty_i) begin
          state_d = (info_i.in_range && info_i.usable) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mdone) begin
          if (step_q == STEP_LAST) begin
            state_d = S_DONE;
          end else begin
            step_d  = step_q + 5'd1;
            state_d = S_MUL;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The sideways decision is captured when the last product completes and
  // applied when the result is handed out.
  logic hold_side_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      valid_q     <= 1'b0;
      conf_q      <= 1'b0;
      side_q      <= 1'b0;
      sit_q       <= 1'b0;
      out_v_q     <= 1'b0;
      hold_side_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == S_WAIT && mdone && step_q == STEP_LAST) begin
        hold_side_q <= side_d;
      end
      if (pop_o) begin
        out_v_q <= 1'b1;
        if (info_i.in_range) begin
          if (!info_i.usable) begin
            valid_q <= 1'b0;
            conf_q  <= 1'b0;
            side_q  <= 1'b0;
            sit_q   <= 1'b0;
          end else begin
            conf_q  <= conf_d;
            side_q  <= hold_side_q;
            sit_q   <= sit_d;
            valid_q <= strict_chk ? (conf_d && !hold_side_q && !sit_d) : 1'b1;
          end
        end
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (info_i.in_range && info_i.usable) begin
        out_q <= {7'd0, info_i.count, sit_d, hold_side_q, conf_d,
                  strict_chk ? (conf_d && !hold_side_q && !sit_d) : 1'b1};
      end else begin
        out_q <= {7'd0, info_i.count, sit_d, side_d, conf_d, valid_d};
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/skeleton_pose_quality_qualifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_pose_quality_qualifier_core
// Qualifies tracked-body frames streamed one joint per word.
// ----------------------------------------------------------------------------
// Joint words are taken one per cycle while the two-frame queue has room.
// A frame is evaluated by a sequence of 22 products on one shared multiplier
// that retires 8 bits of an operand per cycle; the back evaluates one frame
// at a time.
// Reset clears the flags, the joint count, the queue and the output valid flag;
// the key joint store and the output data register hold no reset value.
module skeleton_pose_quality_qualifier_core #(
  parameter int unsigned NUM_JOINTS = spq_pkg::NUM_JOINTS_DEF,
  parameter int unsigned POS_WIDTH  = spq_pkg::POS_WIDTH_DEF,
  localparam int unsigned IN_DW = ((6 + 3 * POS_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spq_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // joint_index, joint_tracked, pos_x, pos_y, pos_z, zero fill
  input  logic [IN_DW-1:0]                s_axis_tdata,
  input  logic                            s_axis_tlast,
  // index_in_range, frame_usable, player_playing, strict_mode
  input  logic [3:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // frame_valid, is_confident, is_sideways, is_sitting, joint_count, zero fill
  output logic [spq_pkg::OUT_DW-1:0]      m_axis_tdata
);

  localparam int unsigned KW = spq_pkg::NUM_SLOTS * 3 * POS_WIDTH;
  localparam int unsigned EW = $bits(spq_pkg::frame_info_t) + KW;

  spq_pkg::cfg_t        cfg_q;
  spq_pkg::frame_info_t f_info, b_info;
  logic [KW-1:0]        f_keys;
  logic [EW-1:0]        head;
  logic                 push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loss   <= spq_pkg::LOSS_RST;
      cfg_q.regain <= spq_pkg::REGAIN_RST;
      cfg_q.cutoff <= spq_pkg::CUTOFF_RST;
      cfg_q.mask   <= spq_pkg::MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spq_pkg::REG_LOSS:   cfg_q.loss   <= cfg_data_i[spq_pkg::THR_W-1:0];
        spq_pkg::REG_REGAIN: cfg_q.regain <= cfg_data_i[spq_pkg::THR_W-1:0];
        spq_pkg::REG_CUTOFF: cfg_q.cutoff <= cfg_data_i[spq_pkg::CUT_W-1:0];
        spq_pkg::REG_MASK:   cfg_q.mask   <= cfg_data_i[spq_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  spq_front #(.NUM_JOINTS(NUM_JOINTS), .POS_WIDTH(POS_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mask_i         (cfg_q.mask),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .joint_index_i  (s_axis_tdata[4:0]),
    .joint_tracked_i(s_axis_tdata[5]),
    .pos_i          (s_axis_tdata[6 +: 3*POS_WIDTH]),
    .last_i         (s_axis_tlast),
    .flags_i        ({s_axis_tuser[3], s_axis_tuser[2], s_axis_tuser[1], s_axis_tuser[0]}),
    .full_i         (full),
    .push_o         (push),
    .info_o         (f_info),
    .keys_o         (f_keys)
  );

  spq_fifo #(.W(EW)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({f_info, f_keys}),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  assign b_info = head[EW-1:KW];

  spq_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .info_i     (b_info),
    .keys_i     (head[KW-1:0]),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
